FILE: hw/rtl/bitmap_block_allocator_core_macros.svh
// Assertion macros for the bitmap block allocator.
// Used by the top level; assumes clk_i and rst_ni are in scope.
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define BBA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bba assertion failed");
`define BBA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("bba assertion failed");
`else
`define BBA_ASSERT(lbl, prop)
`define BBA_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: hw/rtl/bba_pkg.sv
// Shared constants, types and helpers of the bitmap block allocator.
// No dependencies.
package bba_pkg;

  localparam int MapBytes  = 1024;
  localparam int ByteBits  = 8;
  localparam int WordBytes = 4;
  localparam int WordBits  = WordBytes * ByteBits;
  localparam int NumWords  = MapBytes / WordBytes;
  localparam int AddrW     = $clog2(NumWords);
  localparam int BitW      = $clog2(WordBits);
  localparam int GrpSize   = 8;
  localparam int GrpIdxW   = $clog2(GrpSize);
  localparam int NumGrps   = NumWords / GrpSize;
  localparam int GrpW      = $clog2(NumGrps);
  localparam int NumBlocks = MapBytes * ByteBits;
  localparam int PosW      = $clog2(NumBlocks);
  localparam int BlkW      = 14;
  localparam int StatW     = 2;

  localparam logic [StatW-1:0] StOk    = 2'd0;
  localparam logic [StatW-1:0] StFull  = 2'd1;
  localparam logic [StatW-1:0] StRange = 2'd2;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [GrpSize-1:0]  grp_t;

  // write-back notice to the summary flags
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic             full;
  } sum_upd_t;

  function automatic logic [BitW-1:0] first_zero_word(word_t w);
    logic [BitW-1:0] idx;
    logic            found;
    idx   = '0;
    found = 1'b0;
    for (int i = 0; i < WordBits; i++) begin
      if (!found && !w[i]) begin
        idx   = BitW'(i);
        found = 1'b1;
      end
    end
    return idx;
  endfunction

  function automatic logic [GrpIdxW-1:0] first_zero_grp(grp_t g);
    logic [GrpIdxW-1:0] idx;
    logic               found;
    idx   = '0;
    found = 1'b0;
    for (int i = 0; i < GrpSize; i++) begin
      if (!found && !g[i]) begin
        idx   = GrpIdxW'(i);
        found = 1'b1;
      end
    end
    return idx;
  endfunction

endpackage

FILE: hw/rtl/bba_map_ram.sv
// Bitmap word memory: one write port, one read port, registered read data.
// Depends on bba_pkg.
module bba_map_ram import bba_pkg::*; (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output word_t            rdata_o,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  word_t            wdata_i
);

  word_t mem [NumWords];
  word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/bba_summary.sv
// Per-word full and written flags of the bitmap, cleared at reset.
// Depends on bba_pkg.
module bba_summary import bba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [GrpW-1:0]  grp_idx_i,
  output grp_t             grp_full_o,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic             word_vld_o,
  input  sum_upd_t         upd_i
);

  logic [NumWords-1:0] full_q;
  logic [NumWords-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= '0;
      vld_q  <= '0;
    end else if (upd_i.we) begin
      full_q[upd_i.addr] <= upd_i.full;
      vld_q[upd_i.addr]  <= 1'b1;
    end
  end

  assign grp_full_o = full_q[{grp_idx_i, GrpIdxW'(0)} +: GrpSize];
  // a word never written reads as all free
  assign word_vld_o = vld_q[rd_addr_i];

endmodule

FILE: hw/rtl/bitmap_block_allocator_core.sv
// Channel   | direction | handshake
// ----------+-----------+-----------------------------------------------
// command   | in        | start, busy; transfer when start && !busy
// result    | out       | result_valid_o; one cycle, no back-pressure
//
// Allocate: scans 8 word-full flags per cycle, up to 32 groups; the last scan
// cycle also issues the word read, then the modify state updates and writes it back.
// Busy lasts through the scan and the modify state; a full map ends after the scan.
// Free: busy only in the modify state; an out-of-range free never raises busy.
// The result shows the cycle after the last busy cycle.
// Reset clears the per-word flags at once; no sweep of the memory.
// Depends on bba_pkg, bba_map_ram, bba_summary and the macro header.
`include "bitmap_block_allocator_core_macros.svh"

module bitmap_block_allocator_core import bba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             operation_i,
  input  logic [BlkW-1:0]  block_number_i,
  output logic             result_valid_o,
  output logic [BlkW-1:0]  allocated_block_o,
  output logic [StatW-1:0] status_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StMod  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic              op_q, op_d;
  logic [GrpW-1:0]   grp_q, grp_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [BitW-1:0]   bit_q, bit_d;
  logic              res_vld_q, res_vld_d;
  logic [BlkW-1:0]   res_blk_q, res_blk_d;
  logic [StatW-1:0]  res_st_q, res_st_d;

  logic              accept;
  logic              in_range;
  logic [PosW-1:0]   free_pos;
  grp_t              grp_full;
  logic              word_vld;
  word_t             rdata;
  word_t             cur_word;
  word_t             new_word;
  logic [BitW-1:0]   alloc_bit;
  logic              re;
  logic [AddrW-1:0]  raddr;
  sum_upd_t          upd;

  assign accept   = start && !busy;
  assign in_range = (block_number_i != '0) && (block_number_i <= BlkW'(NumBlocks));
  assign free_pos = PosW'(block_number_i - BlkW'(1));

  bba_map_ram u_ram (
    .clk_i   (clk_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata),
    .we_i    (upd.we),
    .waddr_i (addr_q),
    .wdata_i (new_word)
  );

  bba_summary u_sum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .grp_idx_i  (grp_q),
    .grp_full_o (grp_full),
    .rd_addr_i  (addr_q),
    .word_vld_o (word_vld),
    .upd_i      (upd)
  );

  assign cur_word  = word_vld ? rdata : '0;
  assign alloc_bit = first_zero_word(cur_word);

  always_comb begin
    if (op_q == OpFree) begin
      new_word = cur_word & ~(word_t'(1) << bit_q);
    end else begin
      new_word = cur_word | (word_t'(1) << alloc_bit);
    end
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    grp_d     = grp_q;
    addr_d    = addr_q;
    bit_d     = bit_q;
    res_vld_d = 1'b0;
    res_blk_d = res_blk_q;
    res_st_d  = res_st_q;
    re        = 1'b0;
    raddr     = addr_q;
    upd.we    = 1'b0;
    upd.addr  = addr_q;
    upd.full  = &new_word;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          op_d = operation_i;
          if (operation_i == OpAlloc) begin
            grp_d   = '0;
            state_d = StScan;
          end else if (in_range) begin
            raddr   = free_pos[PosW-1 -: AddrW];
            re      = 1'b1;
            addr_d  = raddr;
            bit_d   = free_pos[BitW-1:0];
            state_d = StMod;
          end else begin
            res_vld_d = 1'b1;
            res_blk_d = '0;
            res_st_d  = StRange;
          end
        end
      end
      StScan: begin
        if (grp_full != '1) begin
          raddr   = {grp_q, first_zero_grp(grp_full)};
          re      = 1'b1;
          addr_d  = raddr;
          state_d = StMod;
        end else if (grp_q == GrpW'(NumGrps - 1)) begin
          res_vld_d = 1'b1;
          res_blk_d = '0;
          res_st_d  = StFull;
          state_d   = StIdle;
        end else begin
          grp_d = grp_q + GrpW'(1);
        end
      end
      StMod: begin
        // write lands before any later read: next command starts after this edge
        upd.we    = 1'b1;
        res_vld_d = 1'b1;
        res_st_d  = StOk;
        if (op_q == OpFree) begin
          res_blk_d = '0;
        end else begin
          res_blk_d = BlkW'({addr_q, alloc_bit}) + BlkW'(1);
        end
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    grp_q     <= grp_d;
    addr_q    <= addr_d;
    bit_q     <= bit_d;
    res_blk_q <= res_blk_d;
    res_st_q  <= res_st_d;
  end

  assign busy              = (state_q != StIdle);
  assign result_valid_o    = res_vld_q;
  assign allocated_block_o = res_blk_q;
  assign status_o          = res_st_q;

  `BBA_ASSERT(a_mod_gives_result, (state_q == StMod) |=> result_valid_o)
  `BBA_ASSERT(a_free_goes_mod,
    (accept && operation_i == OpFree && in_range) |=> (state_q == StMod))
  `BBA_ASSERT(a_fail_no_block, (result_valid_o && status_o != StOk) |-> (allocated_block_o == '0))
  `BBA_ASSERT(a_result_ends_work, result_valid_o |-> !busy)

endmodule
